>>> hw/rtl/time_of_day_window_trigger_macros.svh
// ----------------------------------------------------------------------------
// Time-of-day window trigger: assertion macros
// Concurrent checks, clocked on the rising edge and held off during reset.
// ----------------------------------------------------------------------------
`ifndef TIME_OF_DAY_WINDOW_TRIGGER_MACROS_SVH
`define TIME_OF_DAY_WINDOW_TRIGGER_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define TODWT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define TODWT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define TODWT_ASSERT(lbl, clk, rst_n, prop, msg)
`define TODWT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> hw/rtl/todwt_pkg.sv
// ----------------------------------------------------------------------------
// Time-of-day window trigger package
// Request and result types, action and register codes, shared constants.
// ----------------------------------------------------------------------------
package todwt_pkg;

    // Default size of the window table.
    localparam int MAX_WINDOWS_DEF = 16;

    // Field widths.
    localparam int HOUR_W     = 5;
    localparam int MINUTE_W   = 6;
    localparam int SECONDS_W  = 32;
    localparam int DURATION_W = 17;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = DURATION_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_DURATION_SEC  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIT_ENABLE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPIRE_ENABLE = 2'd2;

    localparam logic [DURATION_W-1:0] DURATION_RESET = 17'd3600;

    // Action codes of a request.
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]           action;
        logic [HOUR_W-1:0]    hour;
        logic [MINUTE_W-1:0]  minute;
        logic [SECONDS_W-1:0] now_seconds;
    } todwt_in_t;

    typedef struct packed {
        logic hit;
        logic expired;
        logic active;
        logic table_full;
    } todwt_out_t;

    // One stored window.
    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } todwt_entry_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } todwt_state_t;

endpackage

>>> hw/rtl/todwt_table.sv
// ----------------------------------------------------------------------------
// Window table
// Single-port-write, single-port-read synchronous memory of hour:minute
// windows with a registered read.
// ----------------------------------------------------------------------------
module todwt_table #(
    parameter int DEPTH = todwt_pkg::MAX_WINDOWS_DEF,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [IDX_W-1:0]       wr_addr,
    input  todwt_pkg::todwt_entry_t wr_entry,
    input  logic [IDX_W-1:0]       rd_addr,
    output todwt_pkg::todwt_entry_t rd_entry
);

    import todwt_pkg::*;

    todwt_entry_t mem [DEPTH];
    todwt_entry_t rd_entry_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_entry_reg <= mem[rd_addr];
    end

    assign rd_entry = rd_entry_reg;

endmodule

>>> hw/rtl/time_of_day_window_trigger.sv
// ----------------------------------------------------------------------------
// Time-of-day window trigger
// Keeps a table of hour:minute alarm windows, matches tick requests against
// it and reports window entry, forced expiry and table overflow.
//
//   Channel  Direction  Handshake           Payload
//   in       input      in_valid/in_stall   in_data  (action, hour, minute, seconds)
//   out      output     out_valid/out_stall out_data (hit, expired, active, full)
//   cfg      input      cfg_we              cfg_index, cfg_data
//
// A tick reads the table entries in order up to and including the first
// match (the whole fill level when nothing matches); entries are scanned one
// per cycle through the table's single read port. Add and clear requests
// skip the scan. Reset empties the table by its fill count.
// A stalled result waits in the output register while the next request is
// taken; that request finishes once the output register is free.
// ----------------------------------------------------------------------------
`include "time_of_day_window_trigger_macros.svh"

module time_of_day_window_trigger #(
    parameter int MAX_WINDOWS = todwt_pkg::MAX_WINDOWS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  todwt_pkg::todwt_in_t               in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output todwt_pkg::todwt_out_t              out_data,
    input  logic                               cfg_we,
    input  logic [todwt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [todwt_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import todwt_pkg::*;

    localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOWS + 1);

    // Configuration registers.
    logic [DURATION_W-1:0] duration_reg;
    logic                  hit_enable_reg;
    logic                  expire_enable_reg;

    // Control and window state.
    todwt_state_t          state_reg, state_next;
    logic [IDX_W-1:0]      scan_reg, scan_next;
    logic                  match_reg, match_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  in_window_reg, in_window_next;
    logic [SECONDS_W-1:0]  start_reg, start_next;
    logic                  out_valid_reg, out_valid_next;

    // Payload holding registers.
    todwt_in_t             item_reg, item_next;
    todwt_out_t            out_data_reg, out_data_next;

    // Table ports.
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    todwt_entry_t          wr_entry;
    logic [IDX_W-1:0]      rd_addr;
    todwt_entry_t          rd_entry;

    logic                  entry_match;
    logic                  scan_last;
    logic [SECONDS_W-1:0]  elapsed;
    logic                  timed_out;

    todwt_table #(
        .DEPTH (MAX_WINDOWS)
    ) u_table (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duration_reg      <= DURATION_RESET;
            hit_enable_reg    <= 1'b0;
            expire_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DURATION_SEC:  duration_reg      <= cfg_data;
                CFG_HIT_ENABLE:    hit_enable_reg    <= cfg_data[0];
                CFG_EXPIRE_ENABLE: expire_enable_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Compare the entry read last cycle and check the active window's age.
    assign entry_match = (rd_entry.hour == item_reg.hour) &&
                         (rd_entry.minute == item_reg.minute);
    assign scan_last   = ((CNT_W'(scan_reg) + CNT_W'(1)) == count_reg);
    assign elapsed     = item_reg.now_seconds - start_reg;
    assign timed_out   = (elapsed >= SECONDS_W'(duration_reg));

    // Sequencer: accept, scan the table for a tick, then retire into the output register.
    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        match_next     = match_reg;
        count_next     = count_reg;
        in_window_next = in_window_reg;
        start_next     = start_reg;
        item_next      = item_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = count_reg[IDX_W-1:0];
        wr_entry       = '{hour: item_reg.hour, minute: item_reg.minute};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    match_next = 1'b0;
                    scan_next  = '0;
                    if (in_data.action == ACT_TICK && count_reg != '0)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_SCAN:
            begin
                if (entry_match || scan_last)
                begin
                    match_next = entry_match;
                    state_next = ST_FINISH;
                end
                else
                begin
                    scan_next = scan_reg + IDX_W'(1);
                    rd_addr   = scan_reg + IDX_W'(1);
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next = '0;
                    case (item_reg.action)
                        ACT_TICK:
                        begin
                            if (in_window_reg && expire_enable_reg && timed_out)
                            begin
                                in_window_next        = 1'b0;
                                out_data_next.expired = 1'b1;
                            end
                            else if (match_reg && !in_window_reg)
                            begin
                                in_window_next    = 1'b1;
                                start_next        = item_reg.now_seconds;
                                out_data_next.hit = hit_enable_reg;
                            end
                            else if (!match_reg && in_window_reg)
                            begin
                                in_window_next = 1'b0;
                            end
                        end
                        ACT_ADD:
                        begin
                            if (count_reg < CNT_W'(MAX_WINDOWS))
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                out_data_next.table_full = 1'b1;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next     = '0;
                            in_window_next = 1'b0;
                        end
                        default: ;
                    endcase
                    out_data_next.active = in_window_next;
                    out_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            match_reg     <= 1'b0;
            count_reg     <= '0;
            in_window_reg <= 1'b0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            match_reg     <= match_next;
            count_reg     <= count_next;
            in_window_reg <= in_window_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        out_data_reg <= out_data_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks on the table fill level, the scan and the result flags.
    `TODWT_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(MAX_WINDOWS),
                  "table count overflow")
    `TODWT_ASSERT(a_scan_in_range, clk, rst_n,
                  (state_reg == ST_SCAN) |-> (CNT_W'(scan_reg) < count_reg),
                  "scan beyond fill level")
    `TODWT_NEVER(a_hit_and_expired, clk, rst_n,
                 out_valid_reg && out_data_reg.hit && out_data_reg.expired,
                 "hit and expiry in one result")
    `TODWT_ASSERT(a_result_flag, clk, rst_n,
                  (out_valid_reg && (out_data_reg.hit || out_data_reg.expired ||
                   out_data_reg.table_full)) |->
                  (out_data_reg.active == in_window_reg) ||
                  ($past(state_reg) != ST_FINISH) || out_stall,
                  "result flag does not match window state")

endmodule
